FILE: rtl/core/codepoint_delimiter_splitter_core_defines.svh
// assertion macros used by the splitter core rtl
`ifndef CODEPOINT_DELIMITER_SPLITTER_CORE_DEFINES_SVH
`define CODEPOINT_DELIMITER_SPLITTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("splitter assertion failed");

// next-cycle implication, disabled while in reset
`define CDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("splitter assertion failed");

`endif

FILE: rtl/core/cdsplit_pkg.sv
`timescale 1ns / 1ps

package cdsplit_pkg;

    localparam int CP_W       = 21;
    localparam int LEN_W      = 3;
    localparam int DELIM_REGS = 4;
    localparam int TDATA_W    = 24;
    localparam int TUSER_W    = 3;
    localparam int CFG_IDX_W  = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_CP0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_CP1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_CP2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_CP3 = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [LEN_W-1:0]   len;
    } cell_ctl_t;

    typedef struct packed {
        logic [CP_W-1:0] codepoint;
        logic            has_cp;
        logic            token_end;
        logic            string_end;
        logic            last;
    } result_t;

endpackage

FILE: rtl/core/codepoint_delimiter_splitter_core.sv
`timescale 1ns / 1ps
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+------------------------------------------
// s_axis    | in        | s_axis_tvalid / tready  | tdata: codepoint; tlast: terminator
// m_axis    | out       | m_axis_tvalid / tready  | tdata: out_codepoint; tuser: flags;
//           |           |                         | tlast: last_of_run
// cfg       | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// a codepoint word is taken every cycle while s_axis_tready is high; matching
// against the delimiter is one parallel compare across the window cells
// a terminator (non-empty delimiter) holds off input while the cells shift the
// pending codepoints out one per cycle with room, then the closing marker goes out
// reset is asynchronous and active low; no clearing pass, the fill count marks
// which cells hold live data
// a two-word output buffer decouples m_axis stalls, so input keeps flowing while
// one result waits; a full buffer drops s_axis_tready
`include "codepoint_delimiter_splitter_core_defines.svh"

module codepoint_delimiter_splitter_core
    import cdsplit_pkg::*;
#(
    parameter int MAX_DELIM = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // [20:0] codepoint, [23:21] zero
    input  logic                 s_axis_tlast,   // terminator

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [20:0] out_codepoint, [23:21] zero
    output logic [TUSER_W-1:0]   m_axis_tuser,   // [0] has_codepoint, [1] token_end,
                                                 // [2] string_end
    output logic                 m_axis_tlast,   // last_of_run

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CP_W-1:0]      cfg_data
);

    localparam int FW      = $clog2(MAX_DELIM + 1);
    localparam int CAP_INT = (MAX_DELIM < DELIM_REGS) ? MAX_DELIM : DELIM_REGS;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_INT);

    // configuration registers
    logic [LEN_W-1:0] delim_len_reg;
    logic [CP_W-1:0]  delim_cp_reg [DELIM_REGS];
    logic             cfg_fire;
    logic             cfg_hit;      // index names a real register

    // control state
    logic [FW-1:0]    fill_reg;
    logic [FW-1:0]    fill_next;
    logic             flush_reg;
    logic             flush_next;

    logic [LEN_W-1:0] eff_len;
    logic [FW-1:0]    len_f;
    logic [FW-1:0]    fill_use;
    logic             in_fire;
    logic             room;
    logic             hit;

    cell_ctl_t        ctl;
    logic [CP_W-1:0]  in_cp;
    logic [CP_W-1:0]  cell_value [MAX_DELIM];
    logic [MAX_DELIM-1:0] cell_match;
    logic [MAX_DELIM-1:0] sel_new;

    logic             push;
    result_t          push_word;
    result_t          out_word;

    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign in_cp         = s_axis_tdata[CP_W-1:0];
    assign s_axis_tready = !flush_reg && room;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // register writes; any write to a real register also drops the window
    always_comb
    begin
        case (cfg_index)
            CFG_DELIM_LEN,
            CFG_DELIM_CP0,
            CFG_DELIM_CP1,
            CFG_DELIM_CP2,
            CFG_DELIM_CP3: cfg_hit = 1'b1;
            default:       cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_len_reg <= '0;
            for (int i = 0; i < DELIM_REGS; i++)
            begin
                delim_cp_reg[i] <= '0;
            end
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_DELIM_LEN: delim_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_DELIM_CP0: delim_cp_reg[0] <= cfg_data;
                CFG_DELIM_CP1: delim_cp_reg[1] <= cfg_data;
                CFG_DELIM_CP2: delim_cp_reg[2] <= cfg_data;
                CFG_DELIM_CP3: delim_cp_reg[3] <= cfg_data;
                default:       delim_len_reg   <= delim_len_reg;
            endcase
        end
    end

    // effective delimiter length: capped, and cut at the first zero codepoint
    always_comb
    begin
        logic [LEN_W-1:0] n;
        logic             found;
        n       = (delim_len_reg > LEN_CAP) ? LEN_CAP : delim_len_reg;
        eff_len = n;
        found   = 1'b0;
        for (int i = 0; i < DELIM_REGS; i++)
        begin
            if (!found && (LEN_W'(i) < n) && (delim_cp_reg[i] == '0))
            begin
                eff_len = LEN_W'(i);
                found   = 1'b1;
            end
        end
    end

    // eff_len never exceeds MAX_DELIM, so it fits the fill width
    assign len_f    = FW'(eff_len);
    assign fill_use = (fill_reg >= len_f) ? '0 : fill_reg;

    // window cells, slot 0 is the oldest codepoint
    genvar g;
    generate
        for (g = 0; g < MAX_DELIM; g++)
        begin : g_cell
            logic [CP_W-1:0] shift_in;
            logic [CP_W-1:0] delim_cp;

            assign sel_new[g] = (fill_use == FW'(g));

            if (g + 1 < MAX_DELIM)
            begin : g_mid
                assign shift_in = cell_value[g+1];
            end
            else
            begin : g_end
                assign shift_in = '0;
            end

            if (g < DELIM_REGS)
            begin : g_dcp
                assign delim_cp = delim_cp_reg[g];
            end
            else
            begin : g_nodcp
                assign delim_cp = '0;
            end

            cdsplit_cell #(
                .IDX (g)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .sel_new  (sel_new[g]),
                .cp_in    (in_cp),
                .shift_in (shift_in),
                .delim_cp (delim_cp),
                .value    (cell_value[g]),
                .match    (cell_match[g])
            );
        end
    endgenerate

    assign hit = &cell_match;

    // sequencing of appends, matches and the terminator flush
    always_comb
    begin
        ctl.op     = CELL_HOLD;
        ctl.len    = eff_len;
        fill_next  = fill_reg;
        flush_next = flush_reg;
        push       = 1'b0;
        push_word  = '0;

        if (flush_reg)
        begin
            if (room)
            begin
                push = 1'b1;
                if (fill_reg != '0)
                begin
                    // oldest pending codepoint goes out as content
                    push_word.codepoint = cell_value[0];
                    push_word.has_cp    = 1'b1;
                    ctl.op              = CELL_SHIFT;
                    fill_next           = fill_reg - FW'(1);
                end
                else
                begin
                    push_word.token_end  = 1'b1;
                    push_word.string_end = 1'b1;
                    push_word.last       = 1'b1;
                    flush_next           = 1'b0;
                end
            end
        end
        else if (in_fire)
        begin
            if (s_axis_tlast)
            begin
                if (eff_len == '0)
                begin
                    push                 = 1'b1;
                    push_word.string_end = 1'b1;
                    push_word.last       = 1'b1;
                    fill_next            = '0;
                end
                else
                begin
                    flush_next = 1'b1;
                end
            end
            else if (eff_len == '0)
            begin
                // empty delimiter: one-codepoint tokens
                push                = 1'b1;
                push_word.codepoint = in_cp;
                push_word.has_cp    = 1'b1;
                push_word.token_end = 1'b1;
                push_word.last      = 1'b1;
            end
            else if ((fill_use + FW'(1)) == len_f)
            begin
                push           = 1'b1;
                push_word.last = 1'b1;
                if (hit)
                begin
                    push_word.token_end = 1'b1;
                    fill_next           = '0;
                end
                else
                begin
                    push_word.codepoint = cell_value[0];
                    push_word.has_cp    = 1'b1;
                    ctl.op              = CELL_SHIFT;
                    fill_next           = fill_use;
                end
            end
            else
            begin
                ctl.op    = CELL_LOAD;
                fill_next = fill_use + FW'(1);
            end
        end

        if (cfg_fire && cfg_hit)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            flush_reg <= flush_next;
        end
    end

    cdsplit_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = {{(TDATA_W - CP_W){1'b0}}, out_word.codepoint};
    assign m_axis_tuser = {out_word.string_end, out_word.token_end, out_word.has_cp};
    assign m_axis_tlast = out_word.last;

    // the window never holds a full delimiter between words
    `CDS_ASSERT_NOW(a_fill_below_len, clk, rst_n, (eff_len != '0), (fill_reg < len_f))
    // results are only pushed while the buffer has room
    `CDS_ASSERT_NOW(a_push_room, clk, rst_n, push, room)
    // input is held off for the whole flush
    `CDS_ASSERT_NOW(a_flush_blocks_input, clk, rst_n, flush_reg, !s_axis_tready)
    // an empty window with room clears the flush flag on the next cycle
    `CDS_ASSERT_NEXT(a_flush_closes, clk, rst_n,
        (flush_reg && room && (fill_reg == '0) && !cfg_fire), !flush_reg)

endmodule

FILE: rtl/core/cdsplit_cell.sv
`timescale 1ns / 1ps

module cdsplit_cell
    import cdsplit_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic            clk,
    input  cell_ctl_t       ctl,
    input  logic            sel_new,    // this slot is the append position
    input  logic [CP_W-1:0] cp_in,
    input  logic [CP_W-1:0] shift_in,   // value of the right neighbor
    input  logic [CP_W-1:0] delim_cp,
    output logic [CP_W-1:0] value,
    output logic            match
);

    logic [CP_W-1:0] data_reg;
    logic [CP_W-1:0] data_next;

    // slot content as seen after this cycle's append
    assign value = sel_new ? cp_in : data_reg;
    assign match = (IDX >= int'(ctl.len)) || (value == delim_cp);

    always_comb
    begin
        case (ctl.op)
            CELL_LOAD:  data_next = sel_new ? cp_in : data_reg;
            CELL_SHIFT: data_next = shift_in;
            default:    data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

FILE: rtl/core/cdsplit_out_buf.sv
`timescale 1ns / 1ps

module cdsplit_out_buf
    import cdsplit_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_word,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    result_t     entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        pop;

    assign room      = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_word  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
